FILE: sv/wsn_pkg.sv
// Package for the wheel speed normalizer.
// Holds the widths, pipeline depths and the payload and inter-stage struct types.
// Used by every module of the block; depends on nothing.
package wsn_pkg;

  localparam int unsigned NUM_WHEELS = 6;
  localparam int unsigned IN_WIDTH   = 24;
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned OUT_W      = 16;

  // Quotient width follows the limit width, since a scaled speed never exceeds it.
  localparam int unsigned Q_W    = LIMIT_W;
  localparam int unsigned PROD_W = IN_WIDTH + Q_W;

  // Registered max tree over the wheel magnitudes.
  localparam int unsigned TREE_LVLS = $clog2(NUM_WHEELS);
  localparam int unsigned TREE_N    = 1 << TREE_LVLS;

  // Restoring divider: quotient bits resolved per pipeline stage.
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_STAGES = (Q_W + DIV_STEPS - 1) / DIV_STEPS;

  typedef logic [IN_WIDTH-1:0] mag_t;
  typedef logic [LIMIT_W-1:0]  limit_t;
  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [Q_W-1:0]      quot_t;

  localparam limit_t LIMIT_RESET = limit_t'(32767);

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] speed_a;
    logic signed [IN_WIDTH-1:0] speed_b;
    logic signed [IN_WIDTH-1:0] speed_c;
    logic signed [IN_WIDTH-1:0] speed_d;
    logic signed [IN_WIDTH-1:0] speed_e;
    logic signed [IN_WIDTH-1:0] speed_f;
  } speed_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] setpoint_a;
    logic signed [OUT_W-1:0] setpoint_b;
    logic signed [OUT_W-1:0] setpoint_c;
    logic signed [OUT_W-1:0] setpoint_d;
    logic signed [OUT_W-1:0] setpoint_e;
    logic signed [OUT_W-1:0] setpoint_f;
  } setpoint_out_t;

  // Front end to scale stage: magnitudes, signs and the largest magnitude.
  typedef struct packed {
    mag_t [NUM_WHEELS-1:0] mag;
    logic [NUM_WHEELS-1:0] neg;
    mag_t                  largest;
  } front_t;

  // Scale stage to divider: dividends, common divisor and signs.
  typedef struct packed {
    prod_t [NUM_WHEELS-1:0] prod;
    mag_t                   divisor;
    logic  [NUM_WHEELS-1:0] neg;
  } div_in_t;

  // Divider result: unsigned quotients and signs.
  typedef struct packed {
    quot_t [NUM_WHEELS-1:0] quot;
    logic  [NUM_WHEELS-1:0] neg;
  } div_out_t;

endpackage

FILE: sv/wsn_front.sv
// Front end of the wheel speed normalizer: magnitude and sign per wheel, then a
// registered max tree that finds the largest magnitude.
// Depends on wsn_pkg.
module wsn_front (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  logic                                                    en_i,
  input  logic                                                    valid_i,
  input  logic [wsn_pkg::NUM_WHEELS-1:0][wsn_pkg::IN_WIDTH-1:0]   raw_i,
  output logic                                                    valid_o,
  output wsn_pkg::front_t                                         front_o
);

  logic [wsn_pkg::TREE_LVLS:0]      valid_q;
  wsn_pkg::mag_t                    mag_q [wsn_pkg::TREE_LVLS+1][wsn_pkg::NUM_WHEELS];
  logic [wsn_pkg::NUM_WHEELS-1:0]   neg_q [wsn_pkg::TREE_LVLS+1];
  wsn_pkg::mag_t                    leaf  [wsn_pkg::TREE_N];
  wsn_pkg::mag_t                    heap_d [1:wsn_pkg::TREE_N-1];
  wsn_pkg::mag_t                    heap_q [1:wsn_pkg::TREE_N-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[wsn_pkg::TREE_LVLS-1:0], valid_i};
    end
  end

  // The most negative input has magnitude 2^(IN_WIDTH-1), which still fits mag_t.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int unsigned w = 0; w < wsn_pkg::NUM_WHEELS; w++) begin
        neg_q[0][w] <= raw_i[w][wsn_pkg::IN_WIDTH-1];
        mag_q[0][w] <= raw_i[w][wsn_pkg::IN_WIDTH-1]
                       ? wsn_pkg::mag_t'(~raw_i[w]) + wsn_pkg::mag_t'(1)
                       : wsn_pkg::mag_t'(raw_i[w]);
      end
      for (int unsigned l = 1; l <= wsn_pkg::TREE_LVLS; l++) begin
        mag_q[l] <= mag_q[l-1];
        neg_q[l] <= neg_q[l-1];
      end
      heap_q <= heap_d;
    end
  end

  // Leaves beyond the wheel count read as zero and never win.
  for (genvar i = 0; i < wsn_pkg::TREE_N; i++) begin : g_leaf
    if (i < wsn_pkg::NUM_WHEELS) begin : g_used
      assign leaf[i] = mag_q[0][i];
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // Heap order: node j has children 2j and 2j+1; the deepest level reads the leaves.
  // One tree level is resolved per pipeline stage.
  for (genvar l = 0; l < wsn_pkg::TREE_LVLS; l++) begin : g_lvl
    for (genvar i = 0; i < (wsn_pkg::TREE_N >> (l + 1)); i++) begin : g_node
      localparam int unsigned J = (wsn_pkg::TREE_N >> (l + 1)) + i;
      wsn_pkg::mag_t a;
      wsn_pkg::mag_t b;
      if (l == 0) begin : g_bottom
        assign a = leaf[2*i];
        assign b = leaf[2*i+1];
      end else begin : g_inner
        assign a = heap_q[2*J];
        assign b = heap_q[2*J+1];
      end
      assign heap_d[J] = (a > b) ? a : b;
    end
  end

  assign valid_o         = valid_q[wsn_pkg::TREE_LVLS];
  assign front_o.largest = heap_q[1];

  always_comb begin
    for (int unsigned w = 0; w < wsn_pkg::NUM_WHEELS; w++) begin
      front_o.mag[w] = mag_q[wsn_pkg::TREE_LVLS][w];
      front_o.neg[w] = neg_q[wsn_pkg::TREE_LVLS][w];
    end
  end

endmodule

FILE: sv/wsn_scale.sv
// Scale stage of the wheel speed normalizer: decides whether the set is scaled,
// then forms each dividend as magnitude times limit (times one if not scaled) with one multiplier per wheel.
// Depends on wsn_pkg.
module wsn_scale (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  wsn_pkg::front_t          front_i,
  input  wsn_pkg::limit_t          limit_i,
  output logic                     valid_o,
  output wsn_pkg::div_in_t         div_o
);

  logic                             scale;
  logic                             valid_a_q;
  logic                             valid_b_q;
  wsn_pkg::mag_t                    mag_a_q [wsn_pkg::NUM_WHEELS];
  logic [wsn_pkg::NUM_WHEELS-1:0]   neg_a_q;
  logic [wsn_pkg::NUM_WHEELS-1:0]   neg_b_q;
  wsn_pkg::limit_t                  op_a_q;
  wsn_pkg::mag_t                    div_a_q;
  wsn_pkg::mag_t                    div_b_q;
  wsn_pkg::prod_t                   prod_b_q [wsn_pkg::NUM_WHEELS];

  assign scale = front_i.largest > wsn_pkg::mag_t'(limit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  // A set that is not scaled is divided by one with a multiplier of one, so the
  // divider returns the magnitude unchanged and never sees a zero divisor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int unsigned w = 0; w < wsn_pkg::NUM_WHEELS; w++) begin
        mag_a_q[w]  <= front_i.mag[w];
        prod_b_q[w] <= wsn_pkg::prod_t'(mag_a_q[w]) * wsn_pkg::prod_t'(op_a_q);
      end
      neg_a_q <= front_i.neg;
      op_a_q  <= scale ? limit_i : wsn_pkg::limit_t'(1);
      div_a_q <= scale ? front_i.largest : wsn_pkg::mag_t'(1);
      neg_b_q <= neg_a_q;
      div_b_q <= div_a_q;
    end
  end

  assign valid_o       = valid_b_q;
  assign div_o.divisor = div_b_q;
  assign div_o.neg     = neg_b_q;

  always_comb begin
    for (int unsigned w = 0; w < wsn_pkg::NUM_WHEELS; w++) begin
      div_o.prod[w] = prod_b_q[w];
    end
  end

endmodule

FILE: sv/wsn_div.sv
// Pipelined restoring divider of the wheel speed normalizer, one lane per wheel
// sharing a common divisor; a few quotient bits are resolved in each stage.
// Depends on wsn_pkg.
module wsn_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  wsn_pkg::div_in_t         div_i,
  output logic                     valid_o,
  output wsn_pkg::div_out_t        div_o
);

  // The working word holds the partial remainder above the dividend bits still
  // to be consumed; quotient bits shift in at the bottom. Because the quotient
  // is known to fit Q_W bits, the upper part starts out below the divisor.
  function automatic wsn_pkg::prod_t div_steps(wsn_pkg::prod_t work, wsn_pkg::mag_t d,
                                               int unsigned n);
    logic [wsn_pkg::IN_WIDTH:0] t;
    logic                       ge;
    for (int unsigned k = 0; k < wsn_pkg::DIV_STEPS; k++) begin
      if (k < n) begin
        t  = {work[wsn_pkg::PROD_W-1:wsn_pkg::Q_W], work[wsn_pkg::Q_W-1]};
        ge = t >= {1'b0, d};
        if (ge) begin
          t = t - {1'b0, d};
        end
        work = {t[wsn_pkg::IN_WIDTH-1:0], work[wsn_pkg::Q_W-2:0], ge};
      end
    end
    return work;
  endfunction

  logic [wsn_pkg::DIV_STAGES-1:0]   valid_q;
  wsn_pkg::prod_t                   work_d   [wsn_pkg::DIV_STAGES][wsn_pkg::NUM_WHEELS];
  wsn_pkg::prod_t                   work_q   [wsn_pkg::DIV_STAGES][wsn_pkg::NUM_WHEELS];
  wsn_pkg::mag_t                    div_src  [wsn_pkg::DIV_STAGES];
  wsn_pkg::mag_t                    div_q    [wsn_pkg::DIV_STAGES];
  logic [wsn_pkg::NUM_WHEELS-1:0]   neg_src  [wsn_pkg::DIV_STAGES];
  logic [wsn_pkg::NUM_WHEELS-1:0]   neg_q    [wsn_pkg::DIV_STAGES];

  for (genvar s = 0; s < wsn_pkg::DIV_STAGES; s++) begin : g_stage
    localparam int unsigned Left  = wsn_pkg::Q_W - s * wsn_pkg::DIV_STEPS;
    localparam int unsigned Steps = (Left < wsn_pkg::DIV_STEPS) ? Left : wsn_pkg::DIV_STEPS;
    for (genvar w = 0; w < wsn_pkg::NUM_WHEELS; w++) begin : g_lane
      if (s == 0) begin : g_first
        assign work_d[s][w] = div_steps(div_i.prod[w], div_i.divisor, Steps);
      end else begin : g_next
        assign work_d[s][w] = div_steps(work_q[s-1][w], div_q[s-1], Steps);
      end
    end
    if (s == 0) begin : g_src_first
      assign div_src[s] = div_i.divisor;
      assign neg_src[s] = div_i.neg;
    end else begin : g_src_next
      assign div_src[s] = div_q[s-1];
      assign neg_src[s] = neg_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[wsn_pkg::DIV_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
      div_q  <= div_src;
      neg_q  <= neg_src;
    end
  end

  assign valid_o   = valid_q[wsn_pkg::DIV_STAGES-1];
  assign div_o.neg = neg_q[wsn_pkg::DIV_STAGES-1];

  always_comb begin
    for (int unsigned w = 0; w < wsn_pkg::NUM_WHEELS; w++) begin
      div_o.quot[w] = work_q[wsn_pkg::DIV_STAGES-1][w][wsn_pkg::Q_W-1:0];
    end
  end

endmodule

FILE: sv/wheel_speed_normalizer.sv
// Wheel speed normalizer top level: front end, scale stage, divider, output buffer.
// Throughput is one transfer per cycle while the skid entry is empty; the output
// register and a skid entry keep the input side moving while a result waits, and a
// full skid entry stalls the input and freezes the front end, scale stage and divider.
// Reset empties the pipeline and sets the speed limit to 32767.
// Depends on wsn_pkg, wsn_front, wsn_scale and wsn_div.
module wheel_speed_normalizer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  wsn_pkg::speed_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output wsn_pkg::setpoint_out_t     out_data_o,
  input  logic                       cfg_we_i,
  input  wsn_pkg::limit_t            cfg_wdata_i
);

  wsn_pkg::limit_t                                              limit_q;
  logic                                                         en;
  logic [wsn_pkg::NUM_WHEELS-1:0][wsn_pkg::IN_WIDTH-1:0]        raw;
  logic                                                         front_valid;
  wsn_pkg::front_t                                              front;
  logic                                                         scale_valid;
  wsn_pkg::div_in_t                                             div_in;
  logic                                                         div_valid;
  wsn_pkg::div_out_t                                            div_out;
  logic [wsn_pkg::OUT_W-1:0]                                    sp [wsn_pkg::NUM_WHEELS];
  wsn_pkg::setpoint_out_t                                       res;

  logic                    out_valid_q;
  logic                    out_valid_d;
  logic                    skid_full_q;
  logic                    skid_full_d;
  logic                    out_free;
  logic                    load_out;
  logic                    load_skid;
  logic                    out_from_skid;
  wsn_pkg::setpoint_out_t  out_data_q;
  wsn_pkg::setpoint_out_t  skid_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= wsn_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // The whole pipeline advances unless the skid entry is occupied.
  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  assign raw[0] = in_data_i.speed_a;
  assign raw[1] = in_data_i.speed_b;
  assign raw[2] = in_data_i.speed_c;
  assign raw[3] = in_data_i.speed_d;
  assign raw[4] = in_data_i.speed_e;
  assign raw[5] = in_data_i.speed_f;

  wsn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .raw_i   (raw),
    .valid_o (front_valid),
    .front_o (front)
  );

  wsn_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .front_i (front),
    .limit_i (limit_q),
    .valid_o (scale_valid),
    .div_o   (div_in)
  );

  wsn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (scale_valid),
    .div_i   (div_in),
    .valid_o (div_valid),
    .div_o   (div_out)
  );

  always_comb begin
    for (int unsigned w = 0; w < wsn_pkg::NUM_WHEELS; w++) begin
      sp[w] = div_out.neg[w] ? (~{1'b0, div_out.quot[w]} + wsn_pkg::OUT_W'(1))
                             : {1'b0, div_out.quot[w]};
    end
  end

  assign res.setpoint_a = sp[0];
  assign res.setpoint_b = sp[1];
  assign res.setpoint_c = sp[2];
  assign res.setpoint_d = sp[3];
  assign res.setpoint_e = sp[4];
  assign res.setpoint_f = sp[5];

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_full_d   = skid_full_q;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_full_q) begin
      if (out_free) begin
        out_valid_d   = 1'b1;
        skid_full_d   = 1'b0;
        load_out      = 1'b1;
        out_from_skid = 1'b1;
      end
    end else if (out_free) begin
      out_valid_d = div_valid;
      load_out    = div_valid;
    end else if (div_valid) begin
      skid_full_d = 1'b1;
      load_skid   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= out_from_skid ? skid_data_q : res;
    end
    if (load_skid) begin
      skid_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_valid_q)
    else $error("skid entry holds a transfer while the output register is empty");

  a_skid_fills_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_full_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid entry filled without a stalled output transfer");

  a_skid_drains_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(skid_full_q) |-> $past(!out_stall_i))
    else $error("skid entry drained while the output was stalled");
`endif

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the wheel speed normalizer.
// It needs wsn_pkg and wheel_speed_normalizer. A directed table runs first, then random speed
// sets under several speed limits, checked against an in-bench scaling model or typed setpoints.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [31:0] wval_t;
  typedef wval_t [wsn_pkg::NUM_WHEELS-1:0] wvec_t;

  // Directed row: speed limit, speeds a..f, and setpoints a..f when typed is set.
  typedef struct packed {
    wval_t lim;
    wvec_t spd;
    bit    typed;
    wvec_t sp;
  } row_t;

  typedef enum int unsigned {SPD_FULL, SPD_NEAR_LIMIT, SPD_EDGE, SPD_ZERO} speed_mix_e;

  localparam int N_ROWS    = 22;
  localparam int N_PHASES  = 8;
  localparam int PHASE_LEN = 175;
  localparam int HOLD_LEN  = 300;
  localparam int TAIL_LEN  = 24;

  localparam row_t DIRECTED_ROWS [N_ROWS] = '{
    '{32767, '{0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0}},
    '{32767, '{1, -1, 32767, -32767, 0, 100}, 1'b1, '{1, -1, 32767, -32767, 0, 100}},
    '{32767, '{32768, 0, -1, 1, 0, 0}, 1'b1, '{32767, 0, 0, 0, 0, 0}},
    '{32767, '{8388607, 8388607, 8388607, 8388607, 8388607, 8388607}, 1'b1,
             '{32767, 32767, 32767, 32767, 32767, 32767}},
    '{32767, '{-8388608, -8388608, -8388608, -8388608, -8388608, -8388608}, 1'b1,
             '{-32767, -32767, -32767, -32767, -32767, -32767}},
    '{32767, '{8388607, -8388608, 0, 1, -1, 4194304}, 1'b0, '{default: 0}},
    '{32767, '{1234567, -765432, 99, -4000000, 8000000, -17}, 1'b0, '{default: 0}},
    '{32767, '{-32768, 32767, -16384, 0, 0, 0}, 1'b0, '{default: 0}},
    '{0, '{5, -5, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0}},
    '{0, '{0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0}},
    '{0, '{-8388608, 8388607, 1, -1, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0}},
    '{1, '{5, -5, 2, -3, 0, 1}, 1'b1, '{1, -1, 0, 0, 0, 0}},
    '{1, '{1, -1, 0, 0, -1, 1}, 1'b1, '{1, -1, 0, 0, -1, 1}},
    '{1, '{-8388608, 0, 0, 0, 0, 8388607}, 1'b0, '{default: 0}},
    '{16384, '{16384, -16384, 1, -1, 0, 0}, 1'b1, '{16384, -16384, 1, -1, 0, 0}},
    '{16384, '{-32768, 16384, 0, 0, 0, 0}, 1'b1, '{-16384, 8192, 0, 0, 0, 0}},
    '{16384, '{8388607, -3, 70000, -70000, 5, 0}, 1'b0, '{default: 0}},
    '{100, '{300, -150, 99, -1, 0, 200}, 1'b0, '{default: 0}},
    '{100, '{100, -100, 50, -50, 0, 1}, 1'b1, '{100, -100, 50, -50, 0, 1}},
    '{32767, '{32767, -32767, 32767, -32767, 32767, -32767}, 1'b1,
             '{32767, -32767, 32767, -32767, 32767, -32767}},
    '{32767, '{-8388608, 8388607, -8388608, 8388607, 1, -1}, 1'b0, '{default: 0}},
    '{32767, '{0, 0, 0, 0, 0, -8388608}, 1'b1, '{0, 0, 0, 0, 0, -32767}}
  };

  localparam wsn_pkg::limit_t PHASE_LIMITS [6] = '{15'd32767, 15'd1, 15'd0, 15'd32767,
                                                   15'd100, 15'd20000};

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  wsn_pkg::speed_in_t     in_data_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  wsn_pkg::setpoint_out_t out_data_o;
  logic                   cfg_we_i;
  wsn_pkg::limit_t        cfg_wdata_i;

  wsn_pkg::setpoint_out_t setpoint_q [$];
  wsn_pkg::limit_t        cur_limit = wsn_pkg::LIMIT_RESET;
  bit                     send_idle_on = 1'b1;
  bit                     recv_idle_on = 1'b1;
  bit                     hold_request = 1'b0;
  int unsigned            n_errors  = 0;
  int unsigned            n_sent    = 0;
  int unsigned            n_results = 0;
  int unsigned            n_limits  = 0;
  string                  setpoint_names [wsn_pkg::NUM_WHEELS] = '{"setpoint_a",
                            "setpoint_b", "setpoint_c", "setpoint_d", "setpoint_e",
                            "setpoint_f"};

  wheel_speed_normalizer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Scales a set over the limit so its largest magnitude lands on it, truncating toward zero.
  function automatic wsn_pkg::setpoint_out_t normalize_speeds(wsn_pkg::speed_in_t spd,
                                                              wsn_pkg::limit_t lim);
    longint unsigned              mag [wsn_pkg::NUM_WHEELS];
    bit                           neg [wsn_pkg::NUM_WHEELS];
    longint unsigned              largest;
    longint unsigned              m;
    logic [wsn_pkg::IN_WIDTH-1:0] raw;
    wsn_pkg::setpoint_out_t       res;
    largest = 0;
    for (int w = 0; w < wsn_pkg::NUM_WHEELS; w++) begin
      raw    = spd[(wsn_pkg::NUM_WHEELS-1-w)*wsn_pkg::IN_WIDTH +: wsn_pkg::IN_WIDTH];
      neg[w] = raw[wsn_pkg::IN_WIDTH-1];
      mag[w] = neg[w] ? (64'd1 << wsn_pkg::IN_WIDTH) - 64'(raw) : 64'(raw);
      if (mag[w] > largest) largest = mag[w];
    end
    for (int w = 0; w < wsn_pkg::NUM_WHEELS; w++) begin
      m = mag[w];
      if (largest > 64'(lim)) m = m * 64'(lim) / largest;
      res[(wsn_pkg::NUM_WHEELS-1-w)*wsn_pkg::OUT_W +: wsn_pkg::OUT_W] =
        wsn_pkg::OUT_W'(neg[w] ? 64'd0 - m : m);
    end
    return res;
  endfunction

  function automatic wsn_pkg::speed_in_t to_speeds(wvec_t v);
    wsn_pkg::speed_in_t s;
    for (int j = 0; j < wsn_pkg::NUM_WHEELS; j++)
      s[j*wsn_pkg::IN_WIDTH +: wsn_pkg::IN_WIDTH] = v[j][wsn_pkg::IN_WIDTH-1:0];
    return s;
  endfunction

  function automatic wsn_pkg::setpoint_out_t to_setpoints(wvec_t v);
    wsn_pkg::setpoint_out_t s;
    for (int j = 0; j < wsn_pkg::NUM_WHEELS; j++)
      s[j*wsn_pkg::OUT_W +: wsn_pkg::OUT_W] = v[j][wsn_pkg::OUT_W-1:0];
    return s;
  endfunction

  function automatic logic [wsn_pkg::IN_WIDTH-1:0] pick_speed(speed_mix_e mix,
                                                              wsn_pkg::limit_t lim);
    int span;
    span = int'(lim) + int'(lim) / 4 + 2;
    case (mix)
      SPD_FULL: return wsn_pkg::IN_WIDTH'($urandom);
      SPD_NEAR_LIMIT: return wsn_pkg::IN_WIDTH'(int'($urandom_range(2 * span)) - span);
      SPD_EDGE: begin
        case ($urandom_range(7))
          0: return '0;
          1: return wsn_pkg::IN_WIDTH'(1);
          2: return '1;
          3: return {1'b0, {(wsn_pkg::IN_WIDTH-1){1'b1}}};
          4: return {1'b1, {(wsn_pkg::IN_WIDTH-1){1'b0}}};
          5: return wsn_pkg::IN_WIDTH'(lim);
          6: return wsn_pkg::IN_WIDTH'(int'(lim) + 1);
          default: return wsn_pkg::IN_WIDTH'(-int'(lim));
        endcase
      end
      default: return '0;
    endcase
  endfunction

  // Mostly sets that need scaling, a good share near the limit, some edge values and zeros.
  function automatic wsn_pkg::speed_in_t random_speeds(wsn_pkg::limit_t lim);
    wsn_pkg::speed_in_t s;
    speed_mix_e         mix;
    int unsigned        mode;
    mode = $urandom_range(19);
    for (int j = 0; j < wsn_pkg::NUM_WHEELS; j++) begin
      if (mode < 8) mix = SPD_FULL;
      else if (mode < 14) mix = SPD_NEAR_LIMIT;
      else if (mode < 17) mix = speed_mix_e'($urandom_range(2));
      else if (mode < 19) mix = SPD_EDGE;
      else mix = SPD_ZERO;
      s[j*wsn_pkg::IN_WIDTH +: wsn_pkg::IN_WIDTH] = pick_speed(mix, lim);
    end
    return s;
  endfunction

  function automatic void check_setpoints(wsn_pkg::setpoint_out_t want,
                                          wsn_pkg::setpoint_out_t got);
    logic signed [wsn_pkg::OUT_W-1:0] e;
    logic signed [wsn_pkg::OUT_W-1:0] a;
    n_results++;
    for (int w = 0; w < wsn_pkg::NUM_WHEELS; w++) begin
      e = want[(wsn_pkg::NUM_WHEELS-1-w)*wsn_pkg::OUT_W +: wsn_pkg::OUT_W];
      a = got[(wsn_pkg::NUM_WHEELS-1-w)*wsn_pkg::OUT_W +: wsn_pkg::OUT_W];
      if (e !== a) begin
        $display("%0t: %s expected %0d got %0d", $time, setpoint_names[w], e, a);
        n_errors++;
      end
    end
  endfunction

  // Offers one speed set and returns once the transfer has happened.
  task automatic send_speeds(input wsn_pkg::speed_in_t spd,
                             input wsn_pkg::setpoint_out_t want);
    while (send_idle_on && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= spd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    setpoint_q.push_back(want);
    n_sent++;
  endtask

  task automatic wait_setpoints_drained();
    in_valid_i <= 1'b0;
    while (setpoint_q.size() != 0) @(posedge clk_i);
  endtask

  // Every transfer yields one result, so an empty queue means the pipeline is empty.
  task automatic write_speed_limit(input wsn_pkg::limit_t lim);
    wait_setpoints_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cur_limit = lim;
    n_limits++;
  endtask

  // Result side: checks every transfer and stalls at random or for one long hold-off.
  initial begin : result_side
    wsn_pkg::setpoint_out_t want;
    int unsigned            hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (setpoint_q.size() == 0) begin
          $display("%0t: result with no expected transfer, got %h", $time, out_data_o);
          n_errors++;
        end else begin
          want = setpoint_q.pop_front();
          check_setpoints(want, out_data_o);
        end
      end
      if (hold_request) begin
        hold_left    = HOLD_LEN;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= recv_idle_on && ($urandom_range(99) < 11);
      end
    end
  end

  initial begin : stimulus
    wsn_pkg::speed_in_t     spd;
    wsn_pkg::setpoint_out_t want;
    wsn_pkg::limit_t        lim;
    rst_ni = 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_ROWS; r++) begin
      if (wsn_pkg::limit_t'(DIRECTED_ROWS[r].lim) != cur_limit)
        write_speed_limit(wsn_pkg::limit_t'(DIRECTED_ROWS[r].lim));
      spd  = to_speeds(DIRECTED_ROWS[r].spd);
      want = DIRECTED_ROWS[r].typed ? to_setpoints(DIRECTED_ROWS[r].sp)
                                    : normalize_speeds(spd, cur_limit);
      send_speeds(spd, want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      lim = (p < 6) ? PHASE_LIMITS[p] : wsn_pkg::limit_t'($urandom_range(32767, 1));
      write_speed_limit(lim);
      // Phase 0 opens with a long result hold-off while transfers keep coming;
      // phase 3 opens with a stretch where neither side idles.
      if (p == 0) hold_request = 1'b1;
      send_idle_on = (p != 0) && (p != 3);
      recv_idle_on = (p != 3);
      for (int k = 0; k < PHASE_LEN; k++) begin
        if (p == 0 && k == 80) begin
          wait_setpoints_drained();
          send_idle_on = 1'b1;
        end
        if (p == 3 && k == 150) begin
          send_idle_on = 1'b1;
          recv_idle_on = 1'b1;
        end
        spd = random_speeds(cur_limit);
        send_speeds(spd, normalize_speeds(spd, cur_limit));
      end
    end

    wait_setpoints_drained();
    repeat (TAIL_LEN) @(posedge clk_i);
    if (setpoint_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, setpoint_q.size());
      n_errors++;
    end
    $display("Run covered %0d speed set transfers and %0d checked results", n_sent, n_results);
    $display("under %0d speed limit writes, with %0d mismatches", n_limits, n_errors);
    if (n_errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("%0t: timeout with %0d results outstanding", $time, setpoint_q.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
